@@ design/sgc_pkg.sv @@
// shared types, constants and codes for the sobel gradient classifier
`timescale 1ns / 1ps

package sgc_pkg;

   localparam int MAX_WIDTH  = 2048;
   localparam int MAX_HEIGHT = 2048;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT);

   localparam int SIZE_W     = 12;
   localparam int THRESH_W   = 21;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 21;

   localparam int PIX_W      = 8;
   localparam int SUM_W      = 10;
   localparam int GRAD_W     = 11;
   localparam int ABS_W      = 10;
   localparam int SQ_W       = 2 * ABS_W;
   localparam int MAG_W      = 21;

   // floor(x / 3) for x up to 765 as (x * 683) >> 11
   localparam int GRAY_RECIP = 683;
   localparam int GRAY_SHIFT = 11;
   localparam int GRAY_PROD_W = SUM_W + GRAY_SHIFT;

   localparam int TAN_FRACTION_BITS = 24;
   localparam int TAN_W  = TAN_FRACTION_BITS + 2;
   localparam int PROD_W = TAN_W + ABS_W;
   localparam int YS_W   = ABS_W + TAN_FRACTION_BITS;
   localparam logic [63:0] SQRT2_FRAC_Q64 = 64'h6A09_E667_F3BC_C908;
   localparam logic [63:0] TAN_LOW_Q64 =
      (SQRT2_FRAC_Q64 + (64'd1 << (63 - TAN_FRACTION_BITS))) >> (64 - TAN_FRACTION_BITS);
   localparam logic [TAN_W-1:0] TAN_LOW  = TAN_W'(TAN_LOW_Q64);
   localparam logic [TAN_W-1:0] TAN_HIGH = TAN_LOW + (TAN_W'(2) << TAN_FRACTION_BITS);

   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = FIFO_AW + 1;

   localparam logic [SIZE_W-1:0]   RESET_WIDTH  = 12'd640;
   localparam logic [SIZE_W-1:0]   RESET_HEIGHT = 12'd480;
   localparam logic [THRESH_W-1:0] RESET_LOW    = 21'd1225;
   localparam logic [THRESH_W-1:0] RESET_HIGH   = 21'd122500;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_THRESHOLD  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_THRESHOLD = 2'd3;

   localparam logic [1:0] CLS_NONE   = 2'd0;
   localparam logic [1:0] CLS_WEAK   = 2'd1;
   localparam logic [1:0] CLS_STRONG = 2'd2;

   localparam logic [1:0] DIR_0   = 2'd0;
   localparam logic [1:0] DIR_45  = 2'd1;
   localparam logic [1:0] DIR_90  = 2'd2;
   localparam logic [1:0] DIR_135 = 2'd3;

   typedef struct packed {
      logic             emit;
      logic             last;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
   } sgc_meta_type;

   typedef struct packed {
      logic [10:0]      center_row;
      logic [10:0]      center_col;
      logic [MAG_W-1:0] magnitude;
      logic [1:0]       edge_class;
      logic [1:0]       direction;
      logic             last;
   } sgc_result_type;

endpackage

@@ design/sobel_gradient_classifier_core.sv @@
// top level: position counters, line store banks, sobel pipeline and result queue
`timescale 1ns / 1ps

// Takes one RGB pixel per clock in raster order while req_stall is low and,
// for every interior pixel of the frame, returns its row and column, the
// squared Sobel magnitude, a none/weak/strong class against the two thresholds
// and the direction folded to 0, 45, 90 or 135 degrees; border pixels give no
// result. Sustained rate is one pixel per clock while req_stall is low: each
// pixel does one read of both line store banks and one write of its own bank
// at its column, and the two rows above sit in two 2048 x 8 rams. req_stall
// rises only when the eight-entry result queue plus the items still in the
// pipeline would fill it, i.e. when the rsp side holds back. The line store
// needs no clearing after reset. The user must write image size and thresholds
// through the csr port only while the block is idle; the block does not check.

module sobel_gradient_classifier_core import sgc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [PIX_W-1:0]      req_red,
   input  logic [PIX_W-1:0]      req_green,
   input  logic [PIX_W-1:0]      req_blue,
   input  logic                  req_frame_start,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [10:0]           rsp_center_row,
   output logic [10:0]           rsp_center_col,
   output logic [MAG_W-1:0]      rsp_magnitude,
   output logic [1:0]            rsp_edge_class,
   output logic [1:0]            rsp_direction,
   output logic                  rsp_last
);

   logic [SIZE_W-1:0]   width_ff, height_ff;
   logic [THRESH_W-1:0] low_ff, high_ff;

   logic [COL_W:0]   w, c0, c1, cn;
   logic [ROW_W:0]   h, r0, r1, r2, rn;
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic             accept, bank;
   sgc_meta_type     meta;

   logic [SUM_W-1:0]       rgb_sum;
   logic [GRAY_PROD_W-1:0] gray_prod;
   logic [PIX_W-1:0]       gray;

   logic             b_valid_ff;
   sgc_meta_type     b_meta_ff;
   logic [PIX_W-1:0] b_gray_ff;
   logic             b_bank_ff;
   logic [PIX_W-1:0] bank0_data, bank1_data;

   logic                     w_valid;
   sgc_meta_type             w_meta;
   logic signed [GRAD_W-1:0] w_gx, w_gy;
   logic                     g_mid_valid, g_valid;
   sgc_result_type           g_result, head;
   logic [FIFO_CNT_W-1:0]    fifo_count;
   logic [FIFO_CNT_W:0]      pending;
   logic                     pop;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RESET_WIDTH;
         height_ff <= RESET_HEIGHT;
         low_ff    <= RESET_LOW;
         high_ff   <= RESET_HIGH;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:    width_ff  <= csr_wdata[SIZE_W-1:0];
            CSR_IMAGE_HEIGHT:   height_ff <= csr_wdata[SIZE_W-1:0];
            CSR_LOW_THRESHOLD:  low_ff    <= csr_wdata[THRESH_W-1:0];
            CSR_HIGH_THRESHOLD: high_ff   <= csr_wdata[THRESH_W-1:0];
            default:            ;
         endcase
      end
   end

   // clamped frame size
   always_comb begin
      if (width_ff < 3) begin
         w = (COL_W+1)'(3);
      end else if (width_ff > MAX_WIDTH) begin
         w = (COL_W+1)'(MAX_WIDTH);
      end else begin
         w = (COL_W+1)'(width_ff);
      end
      if (height_ff < 3) begin
         h = (ROW_W+1)'(3);
      end else if (height_ff > MAX_HEIGHT) begin
         h = (ROW_W+1)'(MAX_HEIGHT);
      end else begin
         h = (ROW_W+1)'(height_ff);
      end
   end

   // credit check covers every item that may still land in the queue
   assign pending   = (FIFO_CNT_W+1)'(fifo_count)
                      + (FIFO_CNT_W+1)'(b_valid_ff && b_meta_ff.emit)
                      + (FIFO_CNT_W+1)'(w_valid)
                      + (FIFO_CNT_W+1)'(g_mid_valid)
                      + (FIFO_CNT_W+1)'(g_valid);
   assign req_stall = (pending >= (FIFO_CNT_W+1)'(FIFO_DEPTH));
   assign accept    = req_valid && !req_stall;

   // position of this item, with wraps for a shrunk size
   always_comb begin
      c0 = req_frame_start ? '0 : {1'b0, col_ff};
      r0 = req_frame_start ? '0 : {1'b0, row_ff};
      if (c0 >= w) begin
         c1 = '0;
         r1 = r0 + 1'b1;
      end else begin
         c1 = c0;
         r1 = r0;
      end
      r2 = (r1 >= h) ? '0 : r1;
      bank = r2[0];

      meta.emit = (r2 >= 2) && (c1 >= 2);
      meta.last = (r2 == h - 1'b1) && (c1 == w - 1'b1);
      meta.row  = ROW_W'(r2 - 1'b1);
      meta.col  = COL_W'(c1 - 1'b1);

      cn = c1 + 1'b1;
      rn = r2 + 1'b1;
      if (cn >= w) begin
         col_in = '0;
         row_in = (rn >= h) ? '0 : rn[ROW_W-1:0];
      end else begin
         col_in = cn[COL_W-1:0];
         row_in = r2[ROW_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // gray = floor((r + g + b) / 3)
   assign rgb_sum   = SUM_W'(req_red) + SUM_W'(req_green) + SUM_W'(req_blue);
   assign gray_prod = GRAY_PROD_W'(rgb_sum * GRAY_RECIP);
   assign gray      = gray_prod[GRAY_SHIFT +: PIX_W];

   sgc_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_bank0 (
      .clock   (clock),
      .wr_en   (accept && !bank),
      .wr_addr (c1[COL_W-1:0]),
      .wr_data (gray),
      .rd_addr (c1[COL_W-1:0]),
      .rd_data (bank0_data)
   );

   sgc_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_bank1 (
      .clock   (clock),
      .wr_en   (accept && bank),
      .wr_addr (c1[COL_W-1:0]),
      .wr_data (gray),
      .rd_addr (c1[COL_W-1:0]),
      .rd_data (bank1_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      b_meta_ff <= meta;
      b_gray_ff <= gray;
      b_bank_ff <= bank;
   end

   sgc_window u_window (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (b_valid_ff),
      .in_meta    (b_meta_ff),
      .in_gray    (b_gray_ff),
      .in_bank    (b_bank_ff),
      .bank0_data (bank0_data),
      .bank1_data (bank1_data),
      .out_valid  (w_valid),
      .out_meta   (w_meta),
      .out_gx     (w_gx),
      .out_gy     (w_gy)
   );

   sgc_grad u_grad (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (w_valid),
      .in_meta        (w_meta),
      .in_gx          (w_gx),
      .in_gy          (w_gy),
      .low_threshold  (low_ff),
      .high_threshold (high_ff),
      .mid_valid      (g_mid_valid),
      .out_valid      (g_valid),
      .out_result     (g_result)
   );

   assign pop = rsp_valid && !rsp_stall;

   sgc_out_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (g_valid),
      .push_data  (g_result),
      .pop        (pop),
      .head_valid (rsp_valid),
      .head_data  (head),
      .count      (fifo_count)
   );

   assign rsp_center_row = head.center_row;
   assign rsp_center_col = head.center_col;
   assign rsp_magnitude  = head.magnitude;
   assign rsp_edge_class = head.edge_class;
   assign rsp_direction  = head.direction;
   assign rsp_last       = head.last;

endmodule

@@ design/sgc_ram.sv @@
// generic single-port-write ram with registered read, read-first
`timescale 1ns / 1ps

module sgc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/sgc_window.sv @@
// 3x3 gray window fed from the line store, sobel gx and gy
`timescale 1ns / 1ps

module sgc_window import sgc_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  sgc_meta_type             in_meta,
   input  logic [PIX_W-1:0]         in_gray,
   input  logic                     in_bank,
   input  logic [PIX_W-1:0]         bank0_data,
   input  logic [PIX_W-1:0]         bank1_data,
   output logic                     out_valid,
   output sgc_meta_type             out_meta,
   output logic signed [GRAD_W-1:0] out_gx,
   output logic signed [GRAD_W-1:0] out_gy
);

   logic [PIX_W-1:0] win_ff [3][3];
   logic [PIX_W-1:0] win_in [3][3];
   logic [PIX_W-1:0] older, newer;
   logic [SUM_W-1:0] sum_right, sum_left, sum_low, sum_up;
   logic             out_valid_ff;
   sgc_meta_type     out_meta_ff;
   logic signed [GRAD_W-1:0] gx_ff, gy_ff, gx_in, gy_in;

   // the bank being written holds the row two above, the other one the row above
   assign older = in_bank ? bank1_data : bank0_data;
   assign newer = in_bank ? bank0_data : bank1_data;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         win_in[k][0] = win_ff[k][1];
         win_in[k][1] = win_ff[k][2];
      end
      win_in[0][2] = older;
      win_in[1][2] = newer;
      win_in[2][2] = in_gray;
   end

   always_comb begin
      sum_right = SUM_W'(win_in[0][2]) + (SUM_W'(win_in[1][2]) << 1) + SUM_W'(win_in[2][2]);
      sum_left  = SUM_W'(win_in[0][0]) + (SUM_W'(win_in[1][0]) << 1) + SUM_W'(win_in[2][0]);
      sum_low   = SUM_W'(win_in[2][0]) + (SUM_W'(win_in[2][1]) << 1) + SUM_W'(win_in[2][2]);
      sum_up    = SUM_W'(win_in[0][0]) + (SUM_W'(win_in[0][1]) << 1) + SUM_W'(win_in[0][2]);
      gx_in = $signed({1'b0, sum_right}) - $signed({1'b0, sum_left});
      gy_in = $signed({1'b0, sum_low}) - $signed({1'b0, sum_up});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
               win_ff[k][j] <= '0;
            end
         end
      end else begin
         out_valid_ff <= in_valid && in_meta.emit;
         if (in_valid) begin
            win_ff <= win_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      out_meta_ff <= in_meta;
      gx_ff       <= gx_in;
      gy_ff       <= gy_in;
   end

   assign out_valid = out_valid_ff;
   assign out_meta  = out_meta_ff;
   assign out_gx    = gx_ff;
   assign out_gy    = gy_ff;

endmodule

@@ design/sgc_grad.sv @@
// squared magnitude, threshold class and folded direction in two stages
`timescale 1ns / 1ps

module sgc_grad import sgc_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  sgc_meta_type             in_meta,
   input  logic signed [GRAD_W-1:0] in_gx,
   input  logic signed [GRAD_W-1:0] in_gy,
   input  logic [THRESH_W-1:0]      low_threshold,
   input  logic [THRESH_W-1:0]      high_threshold,
   output logic                     mid_valid,
   output logic                     out_valid,
   output sgc_result_type           out_result
);

   logic signed [GRAD_W-1:0] gxf;
   logic [ABS_W-1:0]  ax, ay;

   logic              s1_valid_ff;
   sgc_meta_type      s1_meta_ff;
   logic [SQ_W-1:0]   sqx_ff, sqy_ff;
   logic [PROD_W-1:0] p1_ff, p2_ff;
   logic [ABS_W-1:0]  ay_ff;
   logic              gy_zero_ff, gx_pos_ff, gx_zero_ff;

   logic [MAG_W-1:0]  mag;
   logic [PROD_W-1:0] ys;
   logic [1:0]        cls, dir;

   logic              out_valid_ff;
   sgc_result_type    out_result_ff;

   // fold into the upper half plane: negate both when gy is negative
   always_comb begin
      gxf = in_gy[GRAD_W-1] ? -in_gx : in_gx;
      ax  = gxf[GRAD_W-1] ? ABS_W'(-gxf) : ABS_W'(gxf);
      ay  = in_gy[GRAD_W-1] ? ABS_W'(-in_gy) : ABS_W'(in_gy);
   end

   always_ff @(posedge clock) begin
      s1_meta_ff <= in_meta;
      sqx_ff     <= ax * ax;
      sqy_ff     <= ay * ay;
      p1_ff      <= TAN_LOW * ax;
      p2_ff      <= TAN_HIGH * ax;
      ay_ff      <= ay;
      gy_zero_ff <= (in_gy == '0);
      gx_pos_ff  <= !gxf[GRAD_W-1] && (gxf != '0);
      gx_zero_ff <= (gxf == '0);
   end

   always_comb begin
      mag = MAG_W'(sqx_ff) + MAG_W'(sqy_ff);
      if (mag > high_threshold) begin
         cls = CLS_STRONG;
      end else if (mag > low_threshold) begin
         cls = CLS_WEAK;
      end else begin
         cls = CLS_NONE;
      end
   end

   always_comb begin
      ys = PROD_W'({ay_ff, {TAN_FRACTION_BITS{1'b0}}});
      if (gy_zero_ff) begin
         dir = DIR_0;
      end else if (gx_pos_ff) begin
         if (ys <= p1_ff) begin
            dir = DIR_0;
         end else if (ys <= p2_ff) begin
            dir = DIR_45;
         end else begin
            dir = DIR_90;
         end
      end else if (gx_zero_ff) begin
         dir = DIR_90;
      end else if (ys >= p2_ff) begin
         dir = DIR_90;
      end else if (ys >= p1_ff) begin
         dir = DIR_135;
      end else begin
         dir = DIR_0;
      end
   end

   always_ff @(posedge clock) begin
      out_result_ff.center_row <= s1_meta_ff.row;
      out_result_ff.center_col <= s1_meta_ff.col;
      out_result_ff.magnitude  <= mag;
      out_result_ff.edge_class <= cls;
      out_result_ff.direction  <= dir;
      out_result_ff.last       <= s1_meta_ff.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= in_valid;
         out_valid_ff <= s1_valid_ff;
      end
   end

   assign mid_valid  = s1_valid_ff;
   assign out_valid  = out_valid_ff;
   assign out_result = out_result_ff;

endmodule

@@ design/sgc_out_fifo.sv @@
// result queue between the pipeline and the rsp channel
`timescale 1ns / 1ps

module sgc_out_fifo import sgc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  sgc_result_type        push_data,
   input  logic                  pop,
   output logic                  head_valid,
   output sgc_result_type        head_data,
   output logic [FIFO_CNT_W-1:0] count
);

   sgc_result_type        mem_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [FIFO_CNT_W-1:0] count_ff, count_in;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   assign head_valid = (count_ff != '0);
   assign head_data  = mem_ff[rd_ptr_ff];
   assign count      = count_ff;

endmodule

@@ tb/tb_sobel_gradient_classifier_core.sv @@
// self-checking testbench for the sobel gradient classifier core
`timescale 1ns / 1ps

module tb_sobel_gradient_classifier_core;
   import sgc_pkg::*;

   localparam int          CLOCK_HALF    = 4;
   localparam int unsigned CYCLE_LIMIT   = 500000;
   localparam int          SETTLE_CYCLES = 12;
   localparam int          HOLD_CYCLES   = 300;
   localparam int          LOOP_ITEMS    = 300;
   localparam int          FRAC_BITS     = 24;
   localparam longint unsigned ROOT2_FRAC = 64'h6A09_E667_F3BC_C908;
   // tan(22.5) and tan(67.5) rounded to FRAC_BITS fractional bits
   localparam longint unsigned TAN_22 =
      (ROOT2_FRAC + (64'd1 << (63 - FRAC_BITS))) >> (64 - FRAC_BITS);
   localparam longint unsigned TAN_67 = TAN_22 + (64'd2 << FRAC_BITS);

   typedef enum int {PAT_NOISE, PAT_SMOOTH, PAT_MIXED} pixel_pattern_type;
   typedef enum int {MARK_EACH, MARK_FIRST, MARK_EARLY, MARK_NONE} frame_mark_type;

   logic                  clock;
   logic                  reset           = 1'b1;
   logic                  csr_write       = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index       = '0;
   logic [CSR_DATA_W-1:0] csr_wdata       = '0;
   logic                  req_valid       = 1'b0;
   logic                  req_stall;
   logic [PIX_W-1:0]      req_red         = '0;
   logic [PIX_W-1:0]      req_green       = '0;
   logic [PIX_W-1:0]      req_blue        = '0;
   logic                  req_frame_start = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall       = 1'b0;
   logic [10:0]           rsp_center_row;
   logic [10:0]           rsp_center_col;
   logic [MAG_W-1:0]      rsp_magnitude;
   logic [1:0]            rsp_edge_class;
   logic [1:0]            rsp_direction;
   logic                  rsp_last;

   bit          idling       = 1'b1;
   bit          hold_start   = 1'b0;
   int          hold_left    = 0;
   int unsigned frame_pixels = 9;
   int unsigned cycle_count  = 0;

   sobel_gradient_classifier_core dut (.*);

   function automatic int unsigned fit_size(logic [11:0] v, int unsigned maxv);
      if (v < 3) return 3;
      if (v > maxv) return maxv;
      return v;
   endfunction

   class gradient_scoreboard;
      sgc_result_type pending_edges [$];
      logic [7:0]     gray_rows [2][MAX_WIDTH];
      logic [7:0]     win [3][3];
      int unsigned    col_pos;
      int unsigned    row_pos;
      logic [11:0]    width_reg;
      logic [11:0]    height_reg;
      logic [20:0]    low_reg;
      logic [20:0]    high_reg;
      int unsigned    errors;

      function new();
         foreach (gray_rows[b, c]) gray_rows[b][c] = '0;
         foreach (win[i, j]) win[i][j] = '0;
         col_pos    = 0;
         row_pos    = 0;
         width_reg  = RESET_WIDTH;
         height_reg = RESET_HEIGHT;
         low_reg    = RESET_LOW;
         high_reg   = RESET_HIGH;
         errors     = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_IMAGE_WIDTH:    width_reg  = data[11:0];
            CSR_IMAGE_HEIGHT:   height_reg = data[11:0];
            CSR_LOW_THRESHOLD:  low_reg    = data;
            CSR_HIGH_THRESHOLD: high_reg   = data;
            default: ;
         endcase
      endfunction

      function logic [1:0] fold_dir(int gx, int gy);
         longint unsigned ys, ax;
         if (gy == 0) return DIR_0;
         if (gy < 0) begin
            gy = -gy;
            gx = -gx;
         end
         ys = longint'(gy) << FRAC_BITS;
         if (gx > 0) begin
            ax = gx;
            if (ys <= TAN_22 * ax) return DIR_0;
            if (ys <= TAN_67 * ax) return DIR_45;
            return DIR_90;
         end
         if (gx == 0) return DIR_90;
         ax = -gx;
         if (ys >= TAN_67 * ax) return DIR_90;
         if (ys >= TAN_22 * ax) return DIR_135;
         return DIR_0;
      endfunction

      function void take_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic fs);
         int unsigned    w, h, bank, mag;
         logic [7:0]     gray, older, newer;
         int             gx, gy;
         sgc_result_type edge_res;
         w = fit_size(width_reg, MAX_WIDTH);
         h = fit_size(height_reg, MAX_HEIGHT);
         if (fs) begin
            col_pos = 0;
            row_pos = 0;
         end
         // a shrunk size pushes the position to the next row first
         if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
         end
         if (row_pos >= h) row_pos = 0;
         gray  = 8'((int'(r) + int'(g) + int'(b)) / 3);
         bank  = row_pos & 1;
         older = gray_rows[bank][col_pos];
         newer = gray_rows[bank ^ 1][col_pos];
         gray_rows[bank][col_pos] = gray;
         for (int k = 0; k < 3; k++) begin
            win[k][0] = win[k][1];
            win[k][1] = win[k][2];
         end
         win[0][2] = older;
         win[1][2] = newer;
         win[2][2] = gray;
         if (row_pos >= 2 && col_pos >= 2) begin
            gx = (int'(win[0][2]) + 2 * int'(win[1][2]) + int'(win[2][2]))
               - (int'(win[0][0]) + 2 * int'(win[1][0]) + int'(win[2][0]));
            gy = (int'(win[2][0]) + 2 * int'(win[2][1]) + int'(win[2][2]))
               - (int'(win[0][0]) + 2 * int'(win[0][1]) + int'(win[0][2]));
            mag = gx * gx + gy * gy;
            edge_res.center_row = 11'(row_pos - 1);
            edge_res.center_col = 11'(col_pos - 1);
            edge_res.magnitude  = MAG_W'(mag);
            edge_res.edge_class = (mag > high_reg) ? CLS_STRONG :
                                  (mag > low_reg)  ? CLS_WEAK : CLS_NONE;
            edge_res.direction  = fold_dir(gx, gy);
            edge_res.last       = (row_pos == h - 1) && (col_pos == w - 1);
            pending_edges.insert(pending_edges.size(), edge_res);
         end
         col_pos++;
         if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= h) row_pos = 0;
         end
      endfunction

      function void check_edge(sgc_result_type got);
         sgc_result_type want;
         if (pending_edges.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("ERROR: unexpected edge row %0d col %0d mag %0d", got.center_row,
                        got.center_col, got.magnitude);
            return;
         end
         want = pending_edges.pop_front();
         if (got.center_row !== want.center_row || got.center_col !== want.center_col ||
             got.magnitude !== want.magnitude || got.edge_class !== want.edge_class ||
             got.direction !== want.direction || got.last !== want.last) begin
            errors++;
            if (errors <= 10) begin
               $display("ERROR: edge mismatch, want row %0d col %0d mag %0d class %0d dir %0d last %0d",
                        want.center_row, want.center_col, want.magnitude, want.edge_class,
                        want.direction, want.last);
               $display("                       got row %0d col %0d mag %0d class %0d dir %0d last %0d",
                        got.center_row, got.center_col, got.magnitude, got.edge_class,
                        got.direction, got.last);
            end
         end
      endfunction
   endclass

   gradient_scoreboard sb;

   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF clock = ~clock;
   end

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      sb.write_reg(idx, data);
   endtask

   // only while idle: all edges returned and border pixels out of the pipeline
   task automatic configure(logic [20:0] w, logic [20:0] h, logic [20:0] lo, logic [20:0] hi);
      while (sb.pending_edges.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      write_csr(CSR_IMAGE_WIDTH, w);
      write_csr(CSR_IMAGE_HEIGHT, h);
      write_csr(CSR_LOW_THRESHOLD, lo);
      write_csr(CSR_HIGH_THRESHOLD, hi);
      csr_write <= 1'b0;
      frame_pixels = fit_size(w[11:0], MAX_WIDTH) * fit_size(h[11:0], MAX_HEIGHT);
   endtask

   task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic fs);
      while (idling && $urandom_range(0, 99) < 34) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_red         <= r;
      req_green       <= g;
      req_blue        <= b;
      req_frame_start <= fs;
      do @(posedge clock); while (req_stall !== 1'b0);
      sb.take_pixel(r, g, b, fs);
   endtask

   task automatic stream_pixels(int unsigned count, pixel_pattern_type pattern,
                                frame_mark_type mark);
      int unsigned idx;
      logic [7:0]  r, g, b;
      logic        fs;
      bit          calm;
      idx = 0;
      for (int unsigned n = 0; n < count; n++) begin
         calm = (pattern == PAT_SMOOTH) || (pattern == PAT_MIXED && $urandom_range(0, 1) == 0);
         if (calm) begin
            // low contrast so that none and weak classes show up
            r = 8'($urandom_range(96, 111));
            g = 8'($urandom_range(96, 111));
            b = 8'($urandom_range(96, 111));
         end else begin
            r = 8'($urandom_range(0, 255));
            g = 8'($urandom_range(0, 255));
            b = 8'($urandom_range(0, 255));
         end
         case (mark)
            MARK_EACH:  fs = (idx % frame_pixels == 0);
            MARK_FIRST: fs = (n == 0);
            MARK_EARLY: fs = (idx % frame_pixels == 0) || ($urandom_range(0, 59) == 0);
            default:    fs = 1'b0;
         endcase
         if (fs) idx = 0;
         send_pixel(r, g, b, fs);
         idx++;
      end
      req_valid <= 1'b0;
   endtask

   function automatic logic [20:0] pick_size(int unsigned typical_hi, int unsigned wide_hi);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 10) return 21'($urandom_range(0, 2));
      if (roll < 25) return 21'($urandom_range(typical_hi + 1, wide_hi));
      return 21'($urandom_range(3, typical_hi));
   endfunction

   // result side: checks each accepted item, then holds off or, while idling is set, stalls at random
   initial begin
      sgc_result_type seen;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
            seen.center_row = rsp_center_row;
            seen.center_col = rsp_center_col;
            seen.magnitude  = rsp_magnitude;
            seen.edge_class = rsp_edge_class;
            seen.direction  = rsp_direction;
            seen.last       = rsp_last;
            sb.check_edge(seen);
         end
         if (hold_start) begin
            hold_left  = HOLD_CYCLES;
            hold_start = 1'b0;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= idling && ($urandom_range(0, 99) < 34);
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      int unsigned    loop_items, n;
      logic [20:0]    w, h, lo, hi;
      logic [7:0]     v;
      frame_mark_type mark;
      sb = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // vertical stripe, 5x3, thresholds left at reset
      write_csr(CSR_IMAGE_WIDTH, 21'd5);
      write_csr(CSR_IMAGE_HEIGHT, 21'd3);
      csr_write <= 1'b0;
      for (int row = 0; row < 3; row++) begin
         for (int col = 0; col < 5; col++) begin
            v = (col == 2 || col == 3) ? 8'd255 : 8'd0;
            send_pixel(v, v, v, row == 0 && col == 0);
         end
      end
      req_valid <= 1'b0;

      // diagonal toward the lower left, one truncated gray
      configure(21'd3, 21'd3, 21'd1000, 21'd1040399);
      send_pixel(8'd128, 8'd128, 8'd128, 1'b1);
      send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
      send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
      send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
      send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
      send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
      send_pixel(8'd255, 8'd255, 8'd254, 1'b0);
      send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
      send_pixel(8'd128, 8'd128, 8'd128, 1'b0);
      req_valid <= 1'b0;

      // result side holds off while pixels keep coming
      configure(21'd6, 21'd5, 21'd1225, 21'd40000);
      hold_start = 1'b1;
      stream_pixels(90, PAT_MIXED, MARK_EACH);

      configure(21'd0, 21'd1, 21'd0, 21'd0);
      stream_pixels(72, PAT_NOISE, MARK_EACH);

      configure(21'd2, 21'd20, 21'd2080800, 21'd2080800);
      stream_pixels(120, PAT_MIXED, MARK_FIRST);

      idling = 1'b0;
      configure(21'd30, 21'd8, 21'd5000, 21'd300000);
      stream_pixels(240, PAT_MIXED, MARK_EACH);
      idling = 1'b1;

      configure(21'd3, 21'd4095, 21'd2000, 21'd100000);
      stream_pixels(120, PAT_MIXED, MARK_EACH);

      // stop mid frame, then shrink so both counters fall outside the new size
      configure(21'd10, 21'd10, 21'd1225, 21'd122500);
      stream_pixels(35, PAT_MIXED, MARK_EACH);
      configure(21'd4, 21'd3, 21'd1225, 21'd122500);
      stream_pixels(40, PAT_MIXED, MARK_NONE);

      loop_items = 0;
      while (loop_items < LOOP_ITEMS) begin
         w = pick_size(10, 16);
         h = pick_size(8, 12);
         // unused upper bits of the size registers
         if ($urandom_range(0, 3) == 0) w[20:12] = 9'($urandom_range(1, 511));
         if ($urandom_range(0, 3) == 0) h[20:12] = 9'($urandom_range(1, 511));
         case ($urandom_range(0, 3))
            0: begin
               lo = 21'($urandom_range(0, 3000));
               hi = 21'($urandom_range(lo, 60000));
            end
            1: begin
               lo = 21'($urandom_range(0, 2080800));
               hi = 21'($urandom_range(0, 2080800));
            end
            2: begin
               lo = 21'($urandom_range(0, 500));
               hi = 21'($urandom_range(0, 8000));
            end
            default: begin
               lo = 21'd0;
               hi = 21'd2080800;
            end
         endcase
         configure(w, h, lo, hi);
         n = $urandom_range(frame_pixels, 2 * frame_pixels + 5);
         mark = frame_mark_type'($urandom_range(MARK_EACH, MARK_EARLY));
         stream_pixels(n, pixel_pattern_type'($urandom_range(PAT_NOISE, PAT_MIXED)), mark);
         loop_items += n;
      end

      while (sb.pending_edges.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending_edges.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
